// File: hdl/sxtok_pkg.sv
package sxtok_pkg;

    localparam logic [2:0] KIND_LPAREN  = 3'd0;
    localparam logic [2:0] KIND_RPAREN  = 3'd1;
    localparam logic [2:0] KIND_STRING  = 3'd2;
    localparam logic [2:0] KIND_IDENT   = 3'd3;
    localparam logic [2:0] KIND_INT     = 3'd4;
    localparam logic [2:0] KIND_FLOAT   = 3'd5;
    localparam logic [2:0] KIND_KEYWORD = 3'd6;
    localparam logic [2:0] KIND_EOF     = 3'd7;

    localparam int MAX_RECS = 4;
    localparam int RIDX_W   = $clog2(MAX_RECS);
    localparam int RCNT_W   = $clog2(MAX_RECS + 1);

    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
        logic [2:0] kind;
    } t_rec;

    typedef struct packed {
        logic [RCNT_W-1:0]       cnt;
        t_rec [MAX_RECS-1:0]     rec;
    } t_burst;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: hdl/sexpr_text_tokenizer.sv
// Streaming lexer for S-expression source text.
// Input channel: one source byte per item (i_text_byte), or an end-of-input
// mark (i_end_flag = 1) that flushes any open token and ends with an
// end-of-file record. Accepted when i_valid is high and o_stall is low.
// Output channel: one record per item. record_kind 0 carries a token text
// byte in o_out_byte; record_kind 1 ends a token and carries its type in
// o_token_kind. o_last_of_run marks the final record caused by one input.
// Throughput: one input byte per cycle while each byte yields at most one
// record and i_stall is low; a byte yielding n records (n <= 4) sends them
// one at a time through the single-record output port, and the 4-entry
// burst queue between the lexer and the serializer absorbs such bursts
// before o_stall rises. The records of an input pass through the queue
// and then the registered output stage before they are shown.
// Reset (synchronous, active low) returns the lexer to the idle state
// between tokens and empties the queue and output stage.
// When the receiver raises i_stall, the shown record holds; the queue fills,
// and once it is full o_stall goes high until space frees up.
module sexpr_text_tokenizer
    import sxtok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_flag,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_record_kind,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_token_kind,
    output logic       o_last_of_run
);

    t_q_stat w_q_stat;
    t_burst  w_push_burst;
    t_burst  w_head_burst;
    logic    w_push;
    logic    w_pop;

    sxtok_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_text_byte (i_text_byte),
        .i_end_flag  (i_end_flag),
        .i_q_stat    (w_q_stat),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_burst     (w_push_burst)
    );

    sxtok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_burst (w_push_burst),
        .i_pop   (w_pop),
        .o_burst (w_head_burst),
        .o_stat  (w_q_stat)
    );

    sxtok_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (w_q_stat),
        .i_burst       (w_head_burst),
        .o_pop         (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_record_kind (o_record_kind),
        .o_out_byte    (o_out_byte),
        .o_token_kind  (o_token_kind),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// File: hdl/sxtok_front.sv
module sxtok_front
    import sxtok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_flag,
    input  t_q_stat    i_q_stat,
    output logic       o_stall,
    output logic       o_push,
    output t_burst     o_burst
);

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_SEMI    = 3'd1;
    localparam logic [2:0] M_COMMENT = 3'd2;
    localparam logic [2:0] M_STRING  = 3'd3;
    localparam logic [2:0] M_ESCAPE  = 3'd4;
    localparam logic [2:0] M_IDENT   = 3'd5;
    localparam logic [2:0] M_NUMBER  = 3'd6;
    localparam logic [2:0] M_WORD    = 3'd7;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic in_word(logic [7:0] c);
        return is_digit(c) || is_alpha(c) || c == CH_UNDER || c == CH_POINT;
    endfunction

    function automatic logic in_number(logic [7:0] c);
        return is_digit(c) || c == CH_POINT || c == 8'h65 || c == 8'h45 || c == 8'h78
            || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic t_burst put(t_burst b, logic is_end, logic [7:0] d, logic [2:0] k);
        t_burst o;
        o = b;
        o.rec[b.cnt[RIDX_W-1:0]] = '{is_end: is_end, data: d, kind: k};
        o.cnt = b.cnt + RCNT_W'(1);
        return o;
    endfunction

    logic [2:0] r_mode, n_mode;
    logic       r_point, n_point;
    logic       v_begin;
    t_burst     v_b;
    logic       w_accept;

    assign o_stall  = i_q_stat.full;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_mode  = r_mode;
        n_point = r_point;
        v_begin = 1'b0;
        v_b     = '0;
        if (i_end_flag) begin
            unique case (r_mode)
                M_SEMI: begin
                    v_b = put(v_b, 1'b0, CH_SEMI, KIND_LPAREN);
                    v_b = put(v_b, 1'b1, 8'd0, KIND_KEYWORD);
                end
                M_STRING, M_ESCAPE: v_b = put(v_b, 1'b1, 8'd0, KIND_STRING);
                M_IDENT:  v_b = put(v_b, 1'b1, 8'd0, KIND_IDENT);
                M_NUMBER: v_b = put(v_b, 1'b1, 8'd0, r_point ? KIND_FLOAT : KIND_INT);
                M_WORD:   v_b = put(v_b, 1'b1, 8'd0, KIND_KEYWORD);
                default: ;
            endcase
            v_b     = put(v_b, 1'b1, 8'd0, KIND_EOF);
            n_mode  = M_IDLE;
            n_point = 1'b0;
        end else begin
            unique case (r_mode)
                M_SEMI: begin
                    if (i_text_byte == CH_SEMI) begin
                        n_mode = M_COMMENT;
                    end else begin
                        v_b     = put(v_b, 1'b0, CH_SEMI, KIND_LPAREN);
                        v_b     = put(v_b, 1'b1, 8'd0, KIND_KEYWORD);
                        v_begin = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (i_text_byte == CH_NL) n_mode = M_IDLE;
                end
                M_STRING: begin
                    if (i_text_byte == CH_QUOTE) begin
                        v_b    = put(v_b, 1'b1, 8'd0, KIND_STRING);
                        n_mode = M_IDLE;
                    end else if (i_text_byte == CH_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end else begin
                        v_b = put(v_b, 1'b0, i_text_byte, KIND_LPAREN);
                    end
                end
                M_ESCAPE: begin
                    v_b    = put(v_b, 1'b0, i_text_byte, KIND_LPAREN);
                    n_mode = M_STRING;
                end
                M_IDENT: begin
                    if (in_word(i_text_byte)) begin
                        v_b = put(v_b, 1'b0, i_text_byte, KIND_LPAREN);
                    end else begin
                        v_b     = put(v_b, 1'b1, 8'd0, KIND_IDENT);
                        v_begin = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (in_number(i_text_byte)) begin
                        v_b = put(v_b, 1'b0, i_text_byte, KIND_LPAREN);
                        if (i_text_byte == CH_POINT) n_point = 1'b1;
                    end else begin
                        v_b     = put(v_b, 1'b1, 8'd0, r_point ? KIND_FLOAT : KIND_INT);
                        v_begin = 1'b1;
                    end
                end
                M_WORD: begin
                    if (in_word(i_text_byte)) begin
                        v_b = put(v_b, 1'b0, i_text_byte, KIND_LPAREN);
                    end else begin
                        v_b     = put(v_b, 1'b1, 8'd0, KIND_KEYWORD);
                        v_begin = 1'b1;
                    end
                end
                default: v_begin = 1'b1;
            endcase

            // start of a new token
            if (v_begin) begin
                n_mode  = M_IDLE;
                n_point = 1'b0;
                if (is_space(i_text_byte)) begin
                    n_mode = M_IDLE;
                end else if (i_text_byte == CH_SEMI) begin
                    n_mode = M_SEMI;
                end else if (i_text_byte == CH_LPAR) begin
                    v_b = put(v_b, 1'b0, i_text_byte, KIND_LPAREN);
                    v_b = put(v_b, 1'b1, 8'd0, KIND_LPAREN);
                end else if (i_text_byte == CH_RPAR) begin
                    v_b = put(v_b, 1'b0, i_text_byte, KIND_LPAREN);
                    v_b = put(v_b, 1'b1, 8'd0, KIND_RPAREN);
                end else if (i_text_byte == CH_QUOTE) begin
                    n_mode = M_STRING;
                end else if (i_text_byte == CH_DOLLAR) begin
                    v_b    = put(v_b, 1'b0, i_text_byte, KIND_LPAREN);
                    n_mode = M_IDENT;
                end else if (is_digit(i_text_byte) || i_text_byte == CH_MINUS) begin
                    v_b    = put(v_b, 1'b0, i_text_byte, KIND_LPAREN);
                    n_mode = M_NUMBER;
                end else if (is_alpha(i_text_byte)) begin
                    v_b    = put(v_b, 1'b0, i_text_byte, KIND_LPAREN);
                    n_mode = M_WORD;
                end else begin
                    v_b = put(v_b, 1'b0, i_text_byte, KIND_LPAREN);
                    v_b = put(v_b, 1'b1, 8'd0, KIND_KEYWORD);
                end
            end
        end
    end

    assign o_burst = v_b;
    assign o_push  = w_accept && (v_b.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_point <= 1'b0;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_point <= n_point;
        end
    end

endmodule

// File: hdl/sxtok_queue.sv
module sxtok_queue
    import sxtok_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_burst  i_burst,
    input  logic    i_pop,
    output t_burst  o_burst,
    output t_q_stat o_stat
);

    t_burst            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_CW-1:0]   r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_burst      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_burst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + Q_AW'(1);
            if (w_pop)  r_rp <= r_rp + Q_AW'(1);
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + Q_CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - Q_CW'(1);
            end
        end
    end

endmodule

// File: hdl/sxtok_back.sv
module sxtok_back
    import sxtok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_burst     i_burst,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic       o_record_kind,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_token_kind,
    output logic       o_last_of_run
);

    t_burst            r_burst;
    logic [RIDX_W-1:0] r_idx;
    logic              r_valid;
    logic              w_last;
    t_rec              w_rec;

    assign w_rec  = r_burst.rec[r_idx];
    assign w_last = (RCNT_W'(r_idx) + RCNT_W'(1)) == r_burst.cnt;
    assign o_pop  = !i_q_stat.empty && (!r_valid || (!i_stall && w_last));

    assign o_valid       = r_valid;
    assign o_record_kind = w_rec.is_end;
    assign o_out_byte    = w_rec.data;
    assign o_token_kind  = w_rec.kind;
    assign o_last_of_run = w_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_burst <= i_burst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && !i_stall) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + RIDX_W'(1);
            end
        end
    end

endmodule

// File: hdl/sxtok_check.sv
module sxtok_check
    import sxtok_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_record_kind,
    input logic [7:0] o_out_byte,
    input logic [2:0] o_token_kind,
    input logic       o_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_record_kind) && $stable(o_out_byte)
            && $stable(o_token_kind) && $stable(o_last_of_run))
        else $error("stalled output record changed");

    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind |-> o_out_byte == 8'd0)
        else $error("end record with nonzero byte");

    a_text_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_record_kind |-> o_token_kind == KIND_LPAREN && !o_last_of_run
            || o_valid && !o_record_kind && o_token_kind == KIND_LPAREN)
        else $error("text record with nonzero token kind");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind && o_token_kind == KIND_EOF |-> o_last_of_run)
        else $error("end-of-file record not last of its run");

    // reset leaves both channels idle
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall && !o_valid)
        else $error("channel busy right after reset");

endmodule

bind sexpr_text_tokenizer sxtok_check u_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_record_kind (o_record_kind),
    .o_out_byte    (o_out_byte),
    .o_token_kind  (o_token_kind),
    .o_last_of_run (o_last_of_run)
);
